// ----- hdl/x86_modrm_effective_address_macros.svh -----
`ifndef X86_MODRM_EFFECTIVE_ADDRESS_MACROS_SVH
`define X86_MODRM_EFFECTIVE_ADDRESS_MACROS_SVH

// same-cycle implication
`define MRMEA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define MRMEA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hdl/mrmea_pkg.sv -----
`default_nettype none

package mrmea_pkg;

  localparam int unsigned RegCount = 8;
  localparam int unsigned RegAw    = $clog2(RegCount);

  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_RESOLVE = 1'b1;

  localparam logic [1:0] MOD_NO_DISP = 2'd0;
  localparam logic [1:0] MOD_DISP8   = 2'd1;
  localparam logic [1:0] MOD_DISP32  = 2'd2;
  localparam logic [1:0] MOD_REG     = 2'd3;

  localparam logic [2:0] RM_SIB       = 3'd4;
  localparam logic [2:0] RM_DISP_ONLY = 3'd5;
  localparam logic [2:0] RM_DISP16    = 3'd6;
  localparam logic [2:0] SIB_NO_INDEX = 3'd4;
  localparam logic [2:0] SIB_NO_BASE  = 3'd5;

  localparam logic [1:0] DSIZE_NONE  = 2'd0;
  localparam logic [1:0] DSIZE_BYTE  = 2'd1;
  localparam logic [1:0] DSIZE_WORD  = 2'd2;
  localparam logic [1:0] DSIZE_DWORD = 2'd3;

  localparam logic [7:0] MOD_MASK = 8'hC0;
  localparam logic [7:0] REG_MASK = 8'h38;
  localparam logic [7:0] RM_MASK  = 8'h07;

  typedef struct packed {
    logic        is_register;
    logic [2:0]  reg_field;
    logic [31:0] register_value;
    logic [31:0] effective_address;
    logic        has_sib;
    logic [1:0]  disp_size;
    logic [2:0]  bytes_used;
  } result_t;

  // register file address for the base / rm read port
  function automatic logic [RegAw-1:0] base_addr(input logic [7:0] modrm,
                                                 input logic [7:0] sib);
    logic [1:0] md;
    logic [2:0] rm;
    md = 2'((modrm & MOD_MASK) >> 6);
    rm = 3'(modrm & RM_MASK);
    if (md != MOD_REG && rm == RM_SIB) begin
      return RegAw'(sib & RM_MASK);
    end
    return RegAw'(rm);
  endfunction

  // register file address for the index read port
  function automatic logic [RegAw-1:0] index_addr(input logic [7:0] sib);
    return RegAw'((sib & REG_MASK) >> 3);
  endfunction

endpackage

`default_nettype wire

// ----- hdl/mrmea_in_if.sv -----
`default_nettype none

interface mrmea_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [2:0]  reg_select;
  logic [31:0] write_value;
  logic [7:0]  modrm_byte;
  logic [7:0]  sib_code;
  logic [31:0] displacement;

  modport source (
    output valid, cmd, reg_select, write_value, modrm_byte, sib_code, displacement,
    input  ready
  );
  modport sink (
    input  valid, cmd, reg_select, write_value, modrm_byte, sib_code, displacement,
    output ready
  );
endinterface

`default_nettype wire

// ----- hdl/mrmea_out_if.sv -----
`default_nettype none

interface mrmea_out_if;
  logic        valid;
  logic        ready;
  logic        is_register;
  logic [2:0]  reg_field;
  logic [31:0] register_value;
  logic [31:0] effective_address;
  logic        has_sib;
  logic [1:0]  disp_size;
  logic [2:0]  bytes_used;

  modport source (
    output valid, is_register, reg_field, register_value, effective_address,
           has_sib, disp_size, bytes_used,
    input  ready
  );
  modport sink (
    input  valid, is_register, reg_field, register_value, effective_address,
           has_sib, disp_size, bytes_used,
    output ready
  );
endinterface

`default_nettype wire

// ----- hdl/mrmea_regfile.sv -----
`default_nettype none

module mrmea_regfile
  import mrmea_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             we_i,
  input  wire logic [RegAw-1:0] waddr_i,
  input  wire logic [31:0]      wdata_i,
  input  wire logic             re_i,
  input  wire logic [RegAw-1:0] raddr_a_i,
  input  wire logic [RegAw-1:0] raddr_b_i,
  output logic      [31:0]      rdata_a_o,
  output logic      [31:0]      rdata_b_o
);

  logic [31:0]         mem [RegCount];
  logic [RegCount-1:0] valid_q;
  logic [31:0]         rdata_a_q;
  logic [31:0]         rdata_b_q;

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= valid_q[raddr_a_i] ? mem[raddr_a_i] : '0;
      rdata_b_q <= valid_q[raddr_b_i] ? mem[raddr_b_i] : '0;
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

// ----- hdl/mrmea_calc.sv -----
`default_nettype none

module mrmea_calc
  import mrmea_pkg::*;
(
  input  wire logic        protected_mode_i,
  input  wire logic [7:0]  modrm_i,
  input  wire logic [7:0]  sib_i,
  input  wire logic [31:0] disp_i,
  input  wire logic [31:0] rdata_a_i,
  input  wire logic [31:0] rdata_b_i,
  output result_t          result_o
);

  logic [1:0]  md;
  logic [2:0]  regf;
  logic [2:0]  rm;
  logic [1:0]  scale;
  logic [2:0]  idx;
  logic [2:0]  base;
  logic        sib_used;
  logic [1:0]  dsize;
  logic [31:0] dval;
  logic [31:0] base_term;
  logic [31:0] index_term;
  logic [31:0] ea;
  logic [2:0]  disp_bytes;

  assign md    = 2'((modrm_i & MOD_MASK) >> 6);
  assign regf  = 3'((modrm_i & REG_MASK) >> 3);
  assign rm    = 3'(modrm_i & RM_MASK);
  assign scale = 2'((sib_i & MOD_MASK) >> 6);
  assign idx   = 3'((sib_i & REG_MASK) >> 3);
  assign base  = 3'(sib_i & RM_MASK);

  always_comb begin
    sib_used   = 1'b0;
    dsize      = DSIZE_NONE;
    dval       = '0;
    base_term  = '0;
    index_term = '0;
    ea         = '0;
    if (md == MOD_REG) begin
      ea = '0;
    end else if (!protected_mode_i && md == MOD_NO_DISP && rm == RM_DISP16) begin
      // real-mode direct offset
      dsize = DSIZE_WORD;
      ea    = {16'h0000, disp_i[15:0]};
    end else begin
      sib_used = (rm == RM_SIB);
      if ((md == MOD_NO_DISP && rm == RM_DISP_ONLY) ||
          (md == MOD_NO_DISP && sib_used && base == SIB_NO_BASE) ||
          md == MOD_DISP32) begin
        dsize = DSIZE_DWORD;
        dval  = disp_i;
      end else if (md == MOD_DISP8) begin
        dsize = DSIZE_BYTE;
        dval  = {{24{disp_i[7]}}, disp_i[7:0]};
      end
      if (sib_used) begin
        if (!(md == MOD_NO_DISP && base == SIB_NO_BASE)) begin
          base_term = rdata_a_i;
        end
        if (idx != SIB_NO_INDEX) begin
          index_term = rdata_b_i << scale;
        end
        ea = base_term + index_term + dval;
      end else if (md == MOD_NO_DISP && rm == RM_DISP_ONLY) begin
        ea = dval;
      end else begin
        ea = rdata_a_i + dval;
      end
    end
  end

  assign disp_bytes = (dsize == DSIZE_DWORD) ? 3'd4 : {1'b0, dsize};

  always_comb begin
    result_o                   = '0;
    result_o.is_register       = (md == MOD_REG);
    result_o.reg_field         = regf;
    result_o.register_value    = (md == MOD_REG) ? rdata_a_i : '0;
    result_o.effective_address = ea;
    result_o.has_sib           = sib_used;
    result_o.disp_size         = dsize;
    result_o.bytes_used        = 3'd1 + {2'b00, sib_used} + disp_bytes;
  end

endmodule

`default_nettype wire

// ----- hdl/x86_modrm_effective_address.sv -----
// ModRM/SIB operand resolver with an eight-entry 32-bit register file that
// reset clears to zero. A write transaction (cmd 0) loads one register and
// gives no result; a resolve transaction (cmd 1) gives exactly one result,
// either a register operand with its value or a memory effective address
// with the SIB, displacement size and byte count. One transaction is taken
// every cycle while the output side does not stall; each resolve passes through
// the register file read, then the address adder into the output register.
// The register file is read at the edge that takes a resolve transaction,
// so a write is seen by any resolve taken after it. protected_mode may be
// written only while no resolve transaction is in flight.
`default_nettype none

`include "x86_modrm_effective_address_macros.svh"

module x86_modrm_effective_address
  import mrmea_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_data_i,
  mrmea_in_if.sink         in_i,
  mrmea_out_if.source      out_o
);

  logic        protected_mode_q;
  logic        in_accept;
  logic        adv;
  logic        s1_v_q;
  logic        s1_v_d;
  logic [7:0]  s1_modrm_q;
  logic [7:0]  s1_sib_q;
  logic [31:0] s1_disp_q;
  logic [31:0] rdata_a;
  logic [31:0] rdata_b;
  result_t     calc_res;
  result_t     res_q;
  logic        out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      protected_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      protected_mode_q <= cfg_data_i;
    end
  end

  // output register free or draining this cycle
  assign adv       = !out_v_q || out_o.ready;
  assign in_i.ready = !s1_v_q || adv;
  assign in_accept = in_i.valid && in_i.ready;

  mrmea_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (in_accept && in_i.cmd == CMD_WRITE),
    .waddr_i   (RegAw'(in_i.reg_select)),
    .wdata_i   (in_i.write_value),
    .re_i      (in_accept && in_i.cmd == CMD_RESOLVE),
    .raddr_a_i (base_addr(in_i.modrm_byte, in_i.sib_code)),
    .raddr_b_i (index_addr(in_i.sib_code)),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  always_comb begin
    s1_v_d = s1_v_q;
    if (in_accept) begin
      s1_v_d = (in_i.cmd == CMD_RESOLVE);
    end else if (adv) begin
      s1_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && in_i.cmd == CMD_RESOLVE) begin
      s1_modrm_q <= in_i.modrm_byte;
      s1_sib_q   <= in_i.sib_code;
      s1_disp_q  <= in_i.displacement;
    end
  end

  mrmea_calc u_calc (
    .protected_mode_i (protected_mode_q),
    .modrm_i          (s1_modrm_q),
    .sib_i            (s1_sib_q),
    .disp_i           (s1_disp_q),
    .rdata_a_i        (rdata_a),
    .rdata_b_i        (rdata_b),
    .result_o         (calc_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_v_q) begin
      res_q <= calc_res;
    end
  end

  assign out_o.valid             = out_v_q;
  assign out_o.is_register       = res_q.is_register;
  assign out_o.reg_field         = res_q.reg_field;
  assign out_o.register_value    = res_q.register_value;
  assign out_o.effective_address = res_q.effective_address;
  assign out_o.has_sib           = res_q.has_sib;
  assign out_o.disp_size         = res_q.disp_size;
  assign out_o.bytes_used        = res_q.bytes_used;

  `MRMEA_ASSERT_NEXT(a_write_no_result, clk_i, rst_ni,
    in_accept && in_i.cmd == CMD_WRITE, !s1_v_q)
  `MRMEA_ASSERT_IMPL(a_reg_operand_no_ea, clk_i, rst_ni,
    out_v_q && res_q.is_register, res_q.effective_address == '0 && !res_q.has_sib)
  `MRMEA_ASSERT_IMPL(a_mem_operand_no_value, clk_i, rst_ni,
    out_v_q && !res_q.is_register, res_q.register_value == '0)
  `MRMEA_ASSERT_NEXT(a_stage_moves, clk_i, rst_ni,
    s1_v_q && adv && !in_accept, out_v_q && !s1_v_q)

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
module tb;
  import mrmea_pkg::*;

  localparam int unsigned HalfPeriod     = 5;
  localparam int unsigned ResetCycles    = 7;
  localparam int unsigned SettleCycles   = 6;
  localparam int unsigned RandomPerPhase = 500;
  localparam int unsigned MaxGap         = 15;
  localparam int unsigned CycleLimit     = 1000000;

  typedef struct packed {
    logic        cmd;
    logic [2:0]  reg_select;
    logic [31:0] write_value;
    logic [7:0]  modrm;
    logic [7:0]  sib;
    logic [31:0] displacement;
  } operand_req_t;

  class ea_scoreboard;
    logic [31:0]  gpr [RegCount];
    logic         protected_mode;
    result_t      expected_operands [$];
    int unsigned  writes;
    int unsigned  resolves;
    int unsigned  sib_resolves;
    int unsigned  checked;
    int unsigned  mismatches;

    function new();
      foreach (gpr[i]) gpr[i] = '0;
      protected_mode = 1'b0;
      writes = 0;
      resolves = 0;
      sib_resolves = 0;
      checked = 0;
      mismatches = 0;
    endfunction

    function result_t resolve_operand(operand_req_t req);
      result_t     r;
      logic [1:0]  md;
      logic [2:0]  rm;
      logic [1:0]  scale;
      logic [2:0]  idx;
      logic [2:0]  base;
      logic [31:0] dv;
      logic [31:0] sum;
      r = '0;
      md = req.modrm[7:6];
      rm = req.modrm[2:0];
      scale = req.sib[7:6];
      idx = req.sib[5:3];
      base = req.sib[2:0];
      dv = '0;
      r.reg_field = req.modrm[5:3];
      if (md == MOD_REG) begin
        r.is_register = 1'b1;
        r.register_value = gpr[rm];
      end else if (!protected_mode && md == MOD_NO_DISP && rm == RM_DISP16) begin
        r.disp_size = DSIZE_WORD;
        r.effective_address = {16'h0000, req.displacement[15:0]};
      end else begin
        r.has_sib = (rm == RM_SIB);
        // no-base disp32 only applies to mod 0, either as rm 5 or behind an sib byte with base 5
        if ((md == MOD_NO_DISP && rm == RM_DISP_ONLY) ||
            (md == MOD_NO_DISP && r.has_sib && base == SIB_NO_BASE) ||
            md == MOD_DISP32) begin
          r.disp_size = DSIZE_DWORD;
          dv = req.displacement;
        end else if (md == MOD_DISP8) begin
          r.disp_size = DSIZE_BYTE;
          dv = {{24{req.displacement[7]}}, req.displacement[7:0]};
        end
        if (r.has_sib) begin
          sum = (md == MOD_NO_DISP && base == SIB_NO_BASE) ? 32'h0 : gpr[base];
          if (idx != SIB_NO_INDEX) sum = sum + (gpr[idx] << scale);
          r.effective_address = sum + dv;
        end else if (md == MOD_NO_DISP && rm == RM_DISP_ONLY) begin
          r.effective_address = dv;
        end else begin
          r.effective_address = gpr[rm] + dv;
        end
      end
      r.bytes_used = 3'(1 + int'(r.has_sib) +
                        ((r.disp_size == DSIZE_DWORD) ? 4 : int'(r.disp_size)));
      return r;
    endfunction

    function void note_transaction(operand_req_t req);
      result_t res;
      if (req.cmd == CMD_WRITE) begin
        gpr[req.reg_select] = req.write_value;
        writes++;
      end else begin
        res = resolve_operand(req);
        expected_operands.push_back(res);
        resolves++;
        if (res.has_sib) sib_resolves++;
      end
    endfunction

    function void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_operands.size() == 0) begin
        $error("result transaction with no resolve pending");
        mismatches++;
        return;
      end
      want = expected_operands.pop_front();
      checked++;
      check_field("is_register", 32'(want.is_register), 32'(got.is_register));
      check_field("reg_field", 32'(want.reg_field), 32'(got.reg_field));
      check_field("register_value", want.register_value, got.register_value);
      check_field("effective_address", want.effective_address, got.effective_address);
      check_field("has_sib", 32'(want.has_sib), 32'(got.has_sib));
      check_field("disp_size", 32'(want.disp_size), 32'(got.disp_size));
      check_field("bytes_used", 32'(want.bytes_used), 32'(got.bytes_used));
    endfunction

    function int unsigned pending();
      return expected_operands.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_data_i = 1'b0;
  bit   in_calm = 1'b0;
  bit   out_calm = 1'b0;
  int unsigned cycles = 0;
  ea_scoreboard sb = new();

  mrmea_in_if  in_if ();
  mrmea_out_if out_if ();

  x86_modrm_effective_address i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[x86_modrm_effective_address] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.is_register = out_if.is_register;
      got.reg_field = out_if.reg_field;
      got.register_value = out_if.register_value;
      got.effective_address = out_if.effective_address;
      got.has_sib = out_if.has_sib;
      got.disp_size = out_if.disp_size;
      got.bytes_used = out_if.bytes_used;
      sb.check_result(got);
    end
  end

  // result side backpressure
  initial begin
    int unsigned gap;
    out_if.ready = 1'b0;
    wait (rst_ni);
    forever begin
      gap = out_calm ? 0 : $urandom_range(0, MaxGap);
      if (gap != 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_if.valid && out_if.ready));
    end
  end

  function automatic logic [7:0] make_modrm(logic [1:0] md, logic [2:0] rf, logic [2:0] rm);
    return {md, rf, rm};
  endfunction

  function automatic logic [7:0] make_sib(logic [1:0] scale, logic [2:0] idx,
                                          logic [2:0] base);
    return {scale, idx, base};
  endfunction

  function automatic operand_req_t write_req(logic [2:0] sel, logic [31:0] val);
    operand_req_t req;
    req.cmd = CMD_WRITE;
    req.reg_select = sel;
    req.write_value = val;
    req.modrm = 8'($urandom);
    req.sib = 8'($urandom);
    req.displacement = $urandom;
    return req;
  endfunction

  function automatic operand_req_t resolve_req(logic [7:0] modrm, logic [7:0] sib,
                                               logic [31:0] disp);
    operand_req_t req;
    req.cmd = CMD_RESOLVE;
    req.reg_select = 3'($urandom);
    req.write_value = $urandom;
    req.modrm = modrm;
    req.sib = sib;
    req.displacement = disp;
    return req;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 11))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return {24'($urandom), 8'h80};
      default: return $urandom;
    endcase
  endfunction

  function automatic operand_req_t random_req();
    logic [1:0] md;
    logic [2:0] rm;
    logic [2:0] idx;
    logic [2:0] base;
    md = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 5))
      0: rm = RM_SIB;
      1: rm = RM_DISP_ONLY;
      2: rm = RM_DISP16;
      default: rm = 3'($urandom_range(0, 7));
    endcase
    idx = ($urandom_range(0, 3) == 0) ? SIB_NO_INDEX : 3'($urandom_range(0, 7));
    base = ($urandom_range(0, 3) == 0) ? SIB_NO_BASE : 3'($urandom_range(0, 7));
    if ($urandom_range(0, 3) == 0)
      return write_req(3'($urandom_range(0, 7)), pick_word());
    return resolve_req(make_modrm(md, 3'($urandom_range(0, 7)), rm),
                       make_sib(2'($urandom_range(0, 3)), idx, base), pick_word());
  endfunction

  task automatic send_item(input operand_req_t req);
    int unsigned gap;
    gap = in_calm ? 0 : $urandom_range(0, MaxGap);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.cmd <= req.cmd;
    in_if.reg_select <= req.reg_select;
    in_if.write_value <= req.write_value;
    in_if.modrm_byte <= req.modrm;
    in_if.sib_code <= req.sib;
    in_if.displacement <= req.displacement;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_transaction(req);
  endtask

  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic mode);
    in_if.valid <= 1'b0;
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_data_i <= mode;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.protected_mode = mode;
  endtask

  initial begin
    operand_req_t real_mode_items [$];
    operand_req_t prot_mode_items [$];
    in_if.valid = 1'b0;
    in_if.cmd = CMD_WRITE;
    in_if.reg_select = '0;
    in_if.write_value = '0;
    in_if.modrm_byte = '0;
    in_if.sib_code = '0;
    in_if.displacement = '0;

    real_mode_items = '{
      write_req(3'd0, 32'hFFFF_FFFF), write_req(3'd1, 32'h8000_0000),
      write_req(3'd2, 32'h0000_0000), write_req(3'd3, 32'h7FFF_FFFF),
      write_req(3'd4, 32'h0000_FFFF), write_req(3'd5, 32'hA5A5_A5A5),
      write_req(3'd6, 32'h1234_5678), write_req(3'd7, 32'hFFFF_FFFE),
      // direct disp16, upper displacement bytes ignored
      resolve_req(make_modrm(MOD_NO_DISP, 3'd7, RM_DISP16), 8'hFF, 32'hFFFF_8001),
      resolve_req(make_modrm(MOD_REG, 3'd5, 3'd7), 8'h00, 32'h0),
      resolve_req(make_modrm(MOD_NO_DISP, 3'd0, RM_DISP_ONLY), 8'h00, 32'hFFFF_FFFF),
      resolve_req(make_modrm(MOD_DISP8, 3'd1, 3'd0), 8'h00, 32'h0000_0080),
      resolve_req(make_modrm(MOD_DISP8, 3'd2, 3'd1), 8'h00, 32'hFFFF_FF7F),
      resolve_req(make_modrm(MOD_DISP32, 3'd3, 3'd3), 8'h00, 32'hFFFF_FFFF),
      // sib with neither base nor index
      resolve_req(make_modrm(MOD_NO_DISP, 3'd4, RM_SIB),
                  make_sib(2'd0, SIB_NO_INDEX, SIB_NO_BASE), 32'hDEAD_BEEF),
      // base 5 is a real base once mod is not 0
      resolve_req(make_modrm(MOD_DISP8, 3'd6, RM_SIB),
                  make_sib(2'd1, SIB_NO_INDEX, SIB_NO_BASE), 32'h0000_00FF),
      resolve_req(make_modrm(MOD_NO_DISP, 3'd0, RM_SIB),
                  make_sib(2'd3, 3'd0, 3'd0), 32'h0)
    };
    prot_mode_items = '{
      resolve_req(make_modrm(MOD_NO_DISP, 3'd2, RM_DISP16), 8'h00, 32'hFFFF_FFFF),
      resolve_req(make_modrm(MOD_NO_DISP, 3'd1, RM_SIB),
                  make_sib(2'd3, 3'd7, SIB_NO_BASE), 32'h8000_0000),
      resolve_req(make_modrm(MOD_DISP32, 3'd7, RM_SIB),
                  make_sib(2'd2, 3'd6, 3'd4), 32'h8000_0000)
    };

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_mode(1'b0);
    foreach (real_mode_items[i]) send_item(real_mode_items[i]);
    set_mode(1'b1);
    foreach (prot_mode_items[i]) send_item(prot_mode_items[i]);

    for (int phase = 0; phase < 4; phase++) begin
      set_mode(phase[0]);
      for (int n = 0; n < RandomPerPhase; n++) begin
        // occasional stretches with no idling on either side
        if (n % 100 == 0) begin
          in_calm = ($urandom_range(0, 3) == 0);
          out_calm = ($urandom_range(0, 3) == 0);
        end
        send_item(random_req());
      end
    end

    in_if.valid <= 1'b0;
    wait_idle();
    $display("covered %0d register writes and %0d operand resolves (%0d with sib)",
             sb.writes, sb.resolves, sb.sib_resolves);
    $display("%0d results compared in both addressing modes, %0d mismatches",
             sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[x86_modrm_effective_address] OK");
    end else begin
      $display("[x86_modrm_effective_address] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/mrmea_pkg.sv
hdl/mrmea_in_if.sv
hdl/mrmea_out_if.sv
hdl/mrmea_regfile.sv
hdl/mrmea_calc.sv
hdl/x86_modrm_effective_address.sv
dv/tb.sv
